// ----- src/ptbc_pkg.sv -----
`timescale 1ns / 1ps
package ptbc_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int SPLIT_BITS = 16;
   localparam int TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8;
   localparam longint PIX_MAX   = (64'd1 << PIXEL_BITS) - 64'd1;
   localparam longint SPLIT_MAX = (64'd1 << SPLIT_BITS) - 64'd1;

   localparam int POS_W  = PIXEL_BITS + SPLIT_BITS;
   localparam int FRAC   = 20;
   localparam int Q_W    = FRAC + 1;
   localparam int NUM_W  = POS_W + FRAC + 1;
   localparam longint ONE_Q  = 64'd1 << FRAC;
   localparam longint HALF_Q = 64'd1 << (FRAC - 1);

   localparam int STR_W  = 16;
   localparam int PROD_W = STR_W + Q_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int N_W    = SUM_W;
   localparam int QE_W   = N_W + 1 - 15;
   localparam longint STR_DIV = 64'd32767;

   localparam longint GAIN   = 64'd35 * PIX_MAX;
   localparam int     GAIN_W = $clog2(GAIN + 1);
   localparam int     P_W    = QE_W + GAIN_W;
   localparam int     Z_W    = P_W + 1 - FRAC;
   localparam int     RCP_SHIFT = 33;
   localparam longint RCP    = ((64'd1 << RCP_SHIFT) + 64'd99) / 64'd100;
   localparam int     RCP_W  = $clog2(RCP + 1);
   localparam longint ROUND_ADD = 64'd50 << FRAC;

   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_SHADOW    = 3'd0;
   localparam logic [2:0] REG_DARK      = 3'd1;
   localparam logic [2:0] REG_LIGHT     = 3'd2;
   localparam logic [2:0] REG_HIGHLIGHT = 3'd3;
   localparam logic [2:0] REG_SPLIT_LOW = 3'd4;
   localparam logic [2:0] REG_SPLIT_MID = 3'd5;
   localparam logic [2:0] REG_SPLIT_HIGH = 3'd6;

   typedef enum logic [1:0] {MODE_ZERO, MODE_ONE, MODE_UP, MODE_DOWN} mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [POS_W-1:0]  span;
      logic [POS_W-1:0]  rem;
      logic [Q_W-1:0]    bits;
   } div_type;

endpackage

// ----- src/parametric_tone_band_curve.sv -----
`timescale 1ns / 1ps
// Four-band parametric tone curve for a stream of pixel channel values.
// Input items arrive on req_tvalid/req_tready/req_tdata, one channel value
// per item, and results leave on rsp_tvalid/rsp_tready/rsp_tdata in the
// same order, one result per item.
// Band strengths and the three splits are written through the csr_ APB
// port at byte address 4*index; pready is always high and reads return
// the stored register value. Write registers only while the stream is idle.
// Throughput is one item per cycle unless the output stall below holds the
// pipeline; the pipeline depth is set by the 21-stage restoring divider that
// forms the band fraction, one quotient bit a stage.
// Reset is synchronous: it empties the pipeline, sets the strengths to zero
// and the splits to one quarter, one half and three quarters.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline holds and req_tready drops; nothing is lost or repeated.
module parametric_tone_band_curve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ptbc_pkg::TDATA_W-1:0]  req_tdata,   // [15:0] pixel_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [ptbc_pkg::TDATA_W-1:0]  rsp_tdata,   // [15:0] pixel_out
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ptbc_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int PB = ptbc_pkg::PIXEL_BITS;
   localparam int PW = ptbc_pkg::POS_W;
   localparam int QW = ptbc_pkg::Q_W;
   localparam int DIV_LAST = 1 + QW;
   localparam int LAST = DIV_LAST + 13;

   function automatic ptbc_pkg::div_type make_lane(input ptbc_pkg::mode_type mode,
         input logic [PW-1:0] a, input logic [PW-1:0] b, input logic [PW-1:0] x);
      ptbc_pkg::div_type o;
      logic [PW-1:0] span;
      logic [ptbc_pkg::NUM_W-1:0] num;
      span = b - a;
      num = (ptbc_pkg::NUM_W'(PW'(x - a)) << ptbc_pkg::FRAC)
            + ptbc_pkg::NUM_W'(span >> 1);
      o.mode = mode;
      o.span = span;
      o.rem  = num[ptbc_pkg::NUM_W-1:QW];
      o.bits = num[QW-1:0];
      return o;
   endfunction

   function automatic ptbc_pkg::div_type div_step(input ptbc_pkg::div_type d);
      ptbc_pkg::div_type o;
      logic [PW:0] trial;
      o = d;
      trial = {d.rem, d.bits[QW-1]};
      o.bits = {d.bits[QW-2:0], 1'b0};
      if (trial >= {1'b0, d.span}) begin
         o.rem = PW'(trial - {1'b0, d.span});
         o.bits[0] = 1'b1;
      end else begin
         o.rem = trial[PW-1:0];
      end
      return o;
   endfunction

   logic [15:0]   strength_ff [0:3];
   logic [15:0]   split_ff [0:2];
   logic [PW-1:0] s_ff [0:2];
   logic          cfg_write;
   logic [2:0]    cfg_index;

   logic          en;
   logic          v_ff [0:LAST];
   logic [PB-1:0] px_ff [0:LAST-1];
   logic [PW-1:0] x_ff;

   ptbc_pkg::div_type div_ff [0:QW][0:3];
   ptbc_pkg::div_type lane_in [0:3];

   ptbc_pkg::mode_type m1_mode_ff [0:3];
   ptbc_pkg::mode_type m2_mode_ff [0:3];
   ptbc_pkg::mode_type m3_mode_ff [0:3];
   logic [QW-1:0]   m1_t_ff [0:3];
   logic [QW-1:0]   m1_t2_ff [0:3];
   logic [QW-1:0]   m2_t_ff [0:3];
   logic [QW-1:0]   m2_h_ff [0:3];
   logic [QW-1:0]   m3_term_ff [0:3];
   logic signed [ptbc_pkg::PROD_W-1:0] m4_prod_ff [0:3];
   logic signed [ptbc_pkg::SUM_W-1:0]  m5_sum_ff;
   logic [ptbc_pkg::N_W-1:0]  m6_n_ff;
   logic [ptbc_pkg::N_W-1:0]  m7_n_ff;
   logic [ptbc_pkg::QE_W-1:0] m7_q_ff;
   logic [ptbc_pkg::QE_W-1:0] m8_d_ff;
   logic [ptbc_pkg::P_W-1:0]  m9_p_ff;
   logic [ptbc_pkg::Z_W-1:0]  m10_z_ff;
   logic [ptbc_pkg::Z_W-1:0]  m11_q_ff;
   logic          neg_ff [0:5];
   logic [PB-1:0] out_ff;

   logic [QW-1:0]   t_in [0:3];
   logic [QW-1:0]   t2_in [0:3];
   logic [QW-1:0]   h_in [0:3];
   logic [QW-1:0]   term_in [0:3];
   logic signed [ptbc_pkg::PROD_W-1:0] prod_in [0:3];
   logic signed [ptbc_pkg::SUM_W-1:0]  sum_in;
   logic [ptbc_pkg::N_W-1:0]  n_in;
   logic [ptbc_pkg::N_W:0]    qe_sum;
   logic [ptbc_pkg::N_W:0]    r_in;
   logic [ptbc_pkg::QE_W-1:0] d_in;
   logic [ptbc_pkg::P_W:0]    y_in;
   logic [ptbc_pkg::Z_W+ptbc_pkg::RCP_W-1:0] zq_in;
   logic signed [PB+1:0]      res_in;
   logic [PB-1:0]             out_in;
   logic [PW-1:0]             x_in;
   logic [PW-1:0]             one_pos;

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (cfg_index)
         ptbc_pkg::REG_SHADOW:     csr_prdata = {16'd0, strength_ff[0]};
         ptbc_pkg::REG_DARK:       csr_prdata = {16'd0, strength_ff[1]};
         ptbc_pkg::REG_LIGHT:      csr_prdata = {16'd0, strength_ff[2]};
         ptbc_pkg::REG_HIGHLIGHT:  csr_prdata = {16'd0, strength_ff[3]};
         ptbc_pkg::REG_SPLIT_LOW:  csr_prdata = {16'd0, split_ff[0]};
         ptbc_pkg::REG_SPLIT_MID:  csr_prdata = {16'd0, split_ff[1]};
         ptbc_pkg::REG_SPLIT_HIGH: csr_prdata = {16'd0, split_ff[2]};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   assign en         = !v_ff[LAST] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[LAST];
   assign rsp_tdata  = ptbc_pkg::TDATA_W'(out_ff);
   assign one_pos    = PW'(ptbc_pkg::PIX_MAX * ptbc_pkg::SPLIT_MAX);
   assign x_in       = (PW'(req_tdata[PB-1:0]) << ptbc_pkg::SPLIT_BITS)
                       - PW'(req_tdata[PB-1:0]);

   always_comb begin
      logic [PW-1:0] x;
      x = x_ff;
      if (x == '0) begin
         lane_in[0] = make_lane(ptbc_pkg::MODE_ONE, '0, s_ff[0], x);
      end else if (x >= s_ff[0]) begin
         lane_in[0] = make_lane(ptbc_pkg::MODE_ZERO, '0, s_ff[0], x);
      end else begin
         lane_in[0] = make_lane(ptbc_pkg::MODE_DOWN, '0, s_ff[0], x);
      end
      if (x == '0 || x >= s_ff[1]) begin
         lane_in[1] = make_lane(ptbc_pkg::MODE_ZERO, '0, s_ff[0], x);
      end else if (x <= s_ff[0]) begin
         lane_in[1] = make_lane((x == s_ff[0]) ? ptbc_pkg::MODE_ONE : ptbc_pkg::MODE_UP,
                                '0, s_ff[0], x);
      end else begin
         lane_in[1] = make_lane((s_ff[1] <= s_ff[0]) ? ptbc_pkg::MODE_ZERO
                                : ptbc_pkg::MODE_DOWN, s_ff[0], s_ff[1], x);
      end
      if (x <= s_ff[0] || x >= s_ff[2]) begin
         lane_in[2] = make_lane(ptbc_pkg::MODE_ZERO, s_ff[0], s_ff[1], x);
      end else if (x <= s_ff[1]) begin
         lane_in[2] = make_lane((x == s_ff[1]) ? ptbc_pkg::MODE_ONE : ptbc_pkg::MODE_UP,
                                s_ff[0], s_ff[1], x);
      end else begin
         lane_in[2] = make_lane((s_ff[2] <= s_ff[1]) ? ptbc_pkg::MODE_ZERO
                                : ptbc_pkg::MODE_DOWN, s_ff[1], s_ff[2], x);
      end
      if (x <= s_ff[2] || one_pos <= s_ff[2]) begin
         lane_in[3] = make_lane(ptbc_pkg::MODE_ZERO, s_ff[2], one_pos, x);
      end else if (x >= one_pos) begin
         lane_in[3] = make_lane(ptbc_pkg::MODE_ONE, s_ff[2], one_pos, x);
      end else begin
         lane_in[3] = make_lane(ptbc_pkg::MODE_UP, s_ff[2], one_pos, x);
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         logic [2*QW-1:0] sq;
         logic [3*QW-1:0] hp;
         t_in[i] = (div_ff[QW][i].bits > QW'(ptbc_pkg::ONE_Q))
                   ? QW'(ptbc_pkg::ONE_Q) : div_ff[QW][i].bits;
         sq = (2*QW)'(m1_t_ff[i]) * (2*QW)'(m1_t_ff[i]) + (2*QW)'(ptbc_pkg::HALF_Q);
         t2_in[i] = sq[ptbc_pkg::FRAC +: QW];
         hp = (3*QW)'(m1_t2_ff[i]) * (3*QW)'((3*QW)'(3 * ptbc_pkg::ONE_Q)
              - ((3*QW)'(m2_t_ff[i]) << 1)) + (3*QW)'(ptbc_pkg::HALF_Q);
         h_in[i] = ((hp >> ptbc_pkg::FRAC) > (3*QW)'(ptbc_pkg::ONE_Q))
                   ? QW'(ptbc_pkg::ONE_Q) : hp[ptbc_pkg::FRAC +: QW];
         case (m3_mode_ff[i])
            ptbc_pkg::MODE_ZERO: term_in[i] = '0;
            ptbc_pkg::MODE_ONE:  term_in[i] = QW'(ptbc_pkg::ONE_Q);
            ptbc_pkg::MODE_UP:   term_in[i] = m2_h_ff[i];
            ptbc_pkg::MODE_DOWN: term_in[i] = QW'(ptbc_pkg::ONE_Q) - m2_h_ff[i];
            default:             term_in[i] = '0;
         endcase
         prod_in[i] = ptbc_pkg::PROD_W'($signed(strength_ff[i]) * $signed({1'b0, m3_term_ff[i]}));
      end
   end

   always_comb begin
      logic [ptbc_pkg::SUM_W-1:0] mag;
      sum_in = ptbc_pkg::SUM_W'(m4_prod_ff[0]) + ptbc_pkg::SUM_W'(m4_prod_ff[1])
             + ptbc_pkg::SUM_W'(m4_prod_ff[2]) + ptbc_pkg::SUM_W'(m4_prod_ff[3]);
      mag  = m5_sum_ff[ptbc_pkg::SUM_W-1] ? ptbc_pkg::SUM_W'(-m5_sum_ff)
                                          : ptbc_pkg::SUM_W'(m5_sum_ff);
      n_in = ptbc_pkg::N_W'(mag) + ptbc_pkg::N_W'(ptbc_pkg::STR_DIV / 2);
      qe_sum = (ptbc_pkg::N_W+1)'(m6_n_ff) + (ptbc_pkg::N_W+1)'(m6_n_ff >> 15)
             + (ptbc_pkg::N_W+1)'(m6_n_ff >> 30);
      r_in = (ptbc_pkg::N_W+1)'(m7_n_ff) + (ptbc_pkg::N_W+1)'(m7_q_ff)
             - ((ptbc_pkg::N_W+1)'(m7_q_ff) << 15);
      d_in = m7_q_ff + ((r_in >= (ptbc_pkg::N_W+1)'(ptbc_pkg::STR_DIV))
                        ? ptbc_pkg::QE_W'(1) : ptbc_pkg::QE_W'(0));
      y_in = (ptbc_pkg::P_W+1)'(m9_p_ff) + (ptbc_pkg::P_W+1)'(ptbc_pkg::ROUND_ADD);
      zq_in = (ptbc_pkg::Z_W+ptbc_pkg::RCP_W)'(m10_z_ff)
            * (ptbc_pkg::Z_W+ptbc_pkg::RCP_W)'(ptbc_pkg::RCP);
      if (neg_ff[5]) begin
         res_in = $signed((PB+2)'(px_ff[LAST-1])) - $signed((PB+2)'(m11_q_ff));
      end else begin
         res_in = $signed((PB+2)'(px_ff[LAST-1])) + $signed((PB+2)'(m11_q_ff));
      end
      if (res_in < 0) begin
         out_in = '0;
      end else if (res_in > $signed((PB+2)'(ptbc_pkg::PIX_MAX))) begin
         out_in = PB'(ptbc_pkg::PIX_MAX);
      end else begin
         out_in = res_in[PB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) strength_ff[i] <= '0;
         split_ff[0] <= 16'd16384;
         split_ff[1] <= 16'd32768;
         split_ff[2] <= 16'd49151;
      end else if (cfg_write) begin
         case (cfg_index)
            ptbc_pkg::REG_SHADOW:     strength_ff[0] <= csr_pwdata[15:0];
            ptbc_pkg::REG_DARK:       strength_ff[1] <= csr_pwdata[15:0];
            ptbc_pkg::REG_LIGHT:      strength_ff[2] <= csr_pwdata[15:0];
            ptbc_pkg::REG_HIGHLIGHT:  strength_ff[3] <= csr_pwdata[15:0];
            ptbc_pkg::REG_SPLIT_LOW:  split_ff[0] <= csr_pwdata[15:0];
            ptbc_pkg::REG_SPLIT_MID:  split_ff[1] <= csr_pwdata[15:0];
            ptbc_pkg::REG_SPLIT_HIGH: split_ff[2] <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s_ff[i] <= (PW'(split_ff[i]) << PB) - PW'(split_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LAST; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int k = 1; k <= LAST; k++) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0] <= req_tdata[PB-1:0];
         for (int k = 1; k < LAST; k++) px_ff[k] <= px_ff[k-1];
         x_ff <= x_in;
         for (int i = 0; i < 4; i++) begin
            div_ff[0][i] <= lane_in[i];
            for (int k = 1; k <= QW; k++) div_ff[k][i] <= div_step(div_ff[k-1][i]);
            m1_mode_ff[i] <= div_ff[QW][i].mode;
            m1_t_ff[i]    <= t_in[i];
            m1_t2_ff[i]   <= t2_in[i];
            m2_t_ff[i]    <= m1_t_ff[i];
            m2_mode_ff[i] <= m1_mode_ff[i];
            m2_h_ff[i]    <= h_in[i];
            m3_mode_ff[i] <= m2_mode_ff[i];
            m3_term_ff[i] <= term_in[i];
            m4_prod_ff[i] <= prod_in[i];
         end
         m5_sum_ff <= sum_in;
         m6_n_ff   <= n_in;
         neg_ff[0] <= m5_sum_ff[ptbc_pkg::SUM_W-1];
         for (int k = 1; k < 6; k++) neg_ff[k] <= neg_ff[k-1];
         m7_n_ff  <= m6_n_ff;
         m7_q_ff  <= qe_sum[ptbc_pkg::N_W:15];
         m8_d_ff  <= d_in;
         m9_p_ff  <= ptbc_pkg::P_W'(m8_d_ff) * ptbc_pkg::P_W'(ptbc_pkg::GAIN);
         m10_z_ff <= y_in[ptbc_pkg::P_W:ptbc_pkg::FRAC];
         m11_q_ff <= ptbc_pkg::Z_W'(zq_in >> ptbc_pkg::RCP_SHIFT);
         out_ff   <= out_in;
      end
   end

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[DIV_LAST] && (div_ff[QW][0].mode == ptbc_pkg::MODE_UP
                          || div_ff[QW][0].mode == ptbc_pkg::MODE_DOWN))
      |-> (div_ff[QW][0].bits <= QW'(ptbc_pkg::ONE_Q)))
      else $error("band fraction above one");

   a_term_bound: assert property (@(posedge clock) disable iff (reset)
      v_ff[DIV_LAST+4] |-> (m3_term_ff[1] <= QW'(ptbc_pkg::ONE_Q)
                            && m3_term_ff[2] <= QW'(ptbc_pkg::ONE_Q)))
      else $error("band term above one");

   a_div_fix: assert property (@(posedge clock) disable iff (reset)
      v_ff[DIV_LAST+8] |-> (r_in < (ptbc_pkg::N_W+1)'(2 * ptbc_pkg::STR_DIV)))
      else $error("strength division estimate off by more than one");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int HOLD_LEN = 300;
   localparam int LIMIT = 400000;
   localparam longint Q_ONE = 64'd1 << 20;
   localparam longint Q_HALF = 64'd1 << 19;
   localparam longint PMAX = 64'd65535;

   class tone_scoreboard;
      longint strength[4];
      longint split[3];
      logic [15:0] pixels_due[$];
      int mismatches;
      int results_seen;

      function void set_defaults();
         foreach (strength[i]) strength[i] = 0;
         split[0] = 16384;
         split[1] = 32768;
         split[2] = 49151;
      endfunction

      function void set_reg(int idx, logic [15:0] v);
         if (idx < 4) strength[idx] = longint'($signed(v));
         else if (idx < 7) split[idx - 4] = longint'(v);
      endfunction

      function longint smooth(longint x, longint a, longint b);
         longint span, t, t2, h;
         span = b - a;
         t = (((x - a) << 20) + span / 2) / span;
         if (t > Q_ONE) t = Q_ONE;
         t2 = (t * t + Q_HALF) >>> 20;
         h = (t2 * (3 * Q_ONE - 2 * t) + Q_HALF) >>> 20;
         if (h > Q_ONE) h = Q_ONE;
         return h;
      endfunction

      function longint fade_out(longint x, longint a, longint b);
         if (x <= a) return Q_ONE;
         if (x >= b || b <= a) return 0;
         return Q_ONE - smooth(x, a, b);
      endfunction

      function longint fade_in(longint x, longint a, longint b);
         if (x <= a || b <= a) return 0;
         if (x >= b) return Q_ONE;
         return smooth(x, a, b);
      endfunction

      function longint bump(longint x, longint l, longint p, longint r);
         if (x <= l || x >= r) return 0;
         if (x <= p) return fade_in(x, l, p);
         return fade_out(x, p, r);
      endfunction

      function longint div_round(longint n, longint d);
         longint m, q;
         m = (n < 0) ? -n : n;
         q = (m + d / 2) / d;
         return (n < 0) ? -q : q;
      endfunction

      function logic [15:0] curve(logic [15:0] px);
         longint x, s0, s1, s2, sum, d20, gain, res;
         x = longint'(px) * 65535;
         s0 = split[0] * PMAX;
         s1 = split[1] * PMAX;
         s2 = split[2] * PMAX;
         sum = strength[0] * fade_out(x, 0, s0)
             + strength[1] * bump(x, 0, s0, s1)
             + strength[2] * bump(x, s0, s1, s2)
             + strength[3] * fade_in(x, s2, PMAX * 65535);
         d20 = div_round(sum, 32767);
         gain = div_round(d20 * 35 * PMAX, 100 * Q_ONE);
         res = longint'(px) + gain;
         if (res < 0) res = 0;
         if (res > PMAX) res = PMAX;
         return res[15:0];
      endfunction

      function void note_pixel(logic [15:0] px);
         pixels_due.insert(pixels_due.size(), curve(px));
      endfunction

      function void check_pixel(logic [15:0] got);
         logic [15:0] want;
         results_seen++;
         if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result pixel_out=%0d", got);
            return;
         end
         want = pixels_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("pixel_out mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return pixels_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ptbc_pkg::TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ptbc_pkg::TDATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ptbc_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tone_scoreboard curve_sb = new();
   bit calm = 1'b0;
   int hold_left = 0;
   int cycles = 0;
   int items_sent = 0;
   int settings_used = 0;

   parametric_tone_band_curve dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function bit idle_now();
      return !calm && ($urandom_range(99) < 15);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) curve_sb.note_pixel(req_tdata[15:0]);
         if (rsp_tvalid && rsp_tready) curve_sb.check_pixel(rsp_tdata[15:0]);
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_now();
      end
   end

   task automatic send_pixel(logic [15:0] px);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ptbc_pkg::TDATA_W'(px);
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (curve_sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ptbc_pkg::ADDR_W'({idx, 2'b00});
      csr_pwdata <= {{16{v[15]}}, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      curve_sb.set_reg(int'(idx), v);
   endtask

   task automatic set_curve(logic [15:0] sh, logic [15:0] dk, logic [15:0] lt,
                            logic [15:0] hl, logic [15:0] s0, logic [15:0] s1,
                            logic [15:0] s2);
      drain();
      write_reg(ptbc_pkg::REG_SHADOW, sh);
      write_reg(ptbc_pkg::REG_DARK, dk);
      write_reg(ptbc_pkg::REG_LIGHT, lt);
      write_reg(ptbc_pkg::REG_HIGHLIGHT, hl);
      write_reg(ptbc_pkg::REG_SPLIT_LOW, s0);
      write_reg(ptbc_pkg::REG_SPLIT_MID, s1);
      write_reg(ptbc_pkg::REG_SPLIT_HIGH, s2);
      settings_used++;
   endtask

   function logic [15:0] pick_strength();
      case ($urandom_range(5))
         0: return 16'sd32767;
         1: return -16'sd32767;
         2: return 16'h8000;
         3: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   function logic [15:0] pick_pixel();
      int sel;
      longint p;
      sel = $urandom_range(7);
      if (sel < 4) return 16'($urandom);
      if (sel == 4) return $urandom_range(1) ? 16'hFFFF - 16'($urandom_range(3))
                                             : 16'($urandom_range(3));
      p = curve_sb.split[$urandom_range(2)] + $urandom_range(16) - 8;
      if (p < 0) p = 0;
      if (p > PMAX) p = PMAX;
      return p[15:0];
   endfunction

   task automatic random_phase(int n, int phase_no);
      logic [15:0] s[3];
      logic [15:0] tmp;
      foreach (s[i]) s[i] = 16'($urandom);
      if (phase_no % 3 != 2) begin
         if (s[0] > s[1]) begin tmp = s[0]; s[0] = s[1]; s[1] = tmp; end
         if (s[1] > s[2]) begin tmp = s[1]; s[1] = s[2]; s[2] = tmp; end
         if (s[0] > s[1]) begin tmp = s[0]; s[0] = s[1]; s[1] = tmp; end
      end
      if (phase_no == 4) s[1] = s[0];
      set_curve(pick_strength(), pick_strength(), pick_strength(), pick_strength(),
                s[0], s[1], s[2]);
      calm = (phase_no == 3);
      for (int i = 0; i < n; i++) begin
         if (phase_no == 1 && i == 30) hold_left = HOLD_LEN;
         if (phase_no == 5 && i == 60) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (curve_sb.pending() != 0) @(posedge clock);
         end
         send_pixel(pick_pixel());
      end
      calm = 1'b0;
   endtask

   logic [15:0] edge_pixels [13] = '{16'd0, 16'd1, 16'd65535, 16'd65534, 16'd16383,
                                     16'd16384, 16'd16385, 16'd32768, 16'd49151,
                                     16'd49152, 16'hAAAA, 16'h5555, 16'd8192};

   initial begin
      curve_sb.set_defaults();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
      set_curve(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                16'd16384, 16'd32768, 16'd49151);
      foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
      set_curve(16'h8000, 16'h8000, -16'sd32767, 16'h8000,
                16'd0, 16'd65535, 16'd65535);
      write_reg(REG_UNUSED, 16'h7FFF);
      foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
      set_curve(16'sd20000, -16'sd20000, 16'sd32767, -16'sd32767,
                16'd50000, 16'd30000, 16'd10000);
      foreach (edge_pixels[i]) send_pixel(edge_pixels[i]);
      for (int ph = 0; ph < 6; ph++) random_phase(115, ph);
      drain();
      if (curve_sb.pending() != 0) begin
         curve_sb.mismatches++;
         $display("%0d expected results never arrived", curve_sb.pending());
      end
      $display("Sent %0d pixels over %0d curve settings; %0d results checked, %0d bad.",
               items_sent, settings_used + 1, curve_sb.results_seen,
               curve_sb.mismatches);
      if (curve_sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ptbc_pkg.sv
src/parametric_tone_band_curve.sv
bench/tb.sv
